/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define SFR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/sfr_pkg.sv */
`timescale 1ns / 1ps

package sfr_pkg;

  // frame layout
  localparam logic [7:0] HDR_BYTE    = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;
  localparam int         LOST_BIT    = 2;
  localparam int         FS_BIT      = 3;
  localparam int         STORE_BYTES = 24;
  localparam int         FRAME_LEN   = 25;
  localparam int         NUM_CH      = 16;
  localparam int         CH_W        = 11;
  localparam int         CH_IDX_W    = 4;
  localparam int         POS_W       = 5;

  // widths of the item fields
  localparam int BYTE_W  = 8;
  localparam int TICK_W  = 16;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 2;
  localparam int OUT_W   = 104;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // register reset values and indexes
  localparam logic [TICK_W-1:0]    GAP_RESET    = 16'd30;
  localparam logic [TICK_W-1:0]    WINDOW_RESET = 16'd1000;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 8'd1;

  // input request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_RATE    = 2'd2
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic                take;
    logic                load;
    kind_t               kind;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                last;
    logic                shift_ch;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic window_end;
    logic frame_done;
    logic end_ok;
    logic out_free;
  } ctl_status_t;

endpackage

/* rtl/sbus_frame_receiver_top.sv */
`timescale 1ns / 1ps
// sbus frame receiver
// s_* channel: one word per received uart byte (s_tuser 0, byte in s_tdata)
//   or per millisecond tick (s_tuser 1). m_* channel: result words, kind in
//   m_tuser (0 channel, 1 end-byte error, 2 packet rate), m_tlast on the last
//   result caused by one input word. cfg_*: register writes, always ready;
//   index 0 gap timeout, index 1 rate window, other indexes ignored.
// an input word is taken while the controller is idle; a byte
//   or tick with no result leaves it idle, so the next word follows directly.
// a word with one result holds the controller until the output register is
//   free; results reach m_* through the output register.
// a good frame end emits sixteen channel words, one per cycle from the
//   shift register while m_tready is high.
// while m_tvalid waits on m_tready the pending word holds, and words with no
//   result are still taken; a result-causing word blocks s_tready until its
//   results have entered the output register.
// reset: parser hunts for the header, counters and rate clear, registers
//   return to gap 30 and window 1000 ticks.
module sbus_frame_receiver_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]          s_tdata,   // rx_byte
  input  logic                                s_tuser,   // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // channel_index, channel_value, frame_lost, failsafe, frames_ok,
  // frame_errors, packet_rate, zero pad
  output logic [sfr_pkg::OUT_W-1:0]           m_tdata,
  output logic [sfr_pkg::KIND_W-1:0]          m_tuser,   // result_kind
  output logic                                m_tlast,   // last_of_run
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sfr_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  assign cfg_ready = 1'b1;

  // controller
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  sfr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* rtl/sfr_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  sfr_pkg::ctl_status_t status,
  output sfr_pkg::ctl_cmd_t    cmd
);
  import sfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RATE = 4'b0010,
    ST_ERR  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [CH_IDX_W-1:0] ch_cnt, ch_cnt_next;
  logic                accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // next state and commands
  always_comb begin
    state_next   = state;
    ch_cnt_next  = ch_cnt;
    cmd          = '0;
    cmd.kind     = KIND_CHANNEL;
    cmd.take     = accept;
    cmd.ch_idx   = ch_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.window_end) begin
            state_next = ST_RATE;
          end else if (status.frame_done && status.end_ok) begin
            state_next  = ST_EMIT;
            ch_cnt_next = '0;
          end else if (status.frame_done) begin
            state_next = ST_ERR;
          end
        end
      end
      ST_RATE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_RATE;
          cmd.ch_idx = '0;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_ERROR;
          cmd.ch_idx = '0;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load     = 1'b1;
          cmd.kind     = KIND_CHANNEL;
          cmd.shift_ch = 1'b1;
          cmd.last     = (ch_cnt == CH_IDX_W'(NUM_CH - 1));
          ch_cnt_next  = ch_cnt + 1'b1;
          if (ch_cnt == CH_IDX_W'(NUM_CH - 1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ch_cnt <= '0;
    end else begin
      state  <= state_next;
      ch_cnt <= ch_cnt_next;
    end
  end

  `SFR_ASSERT(a_good_frame_emits, accept && status.frame_done && status.end_ok && !status.window_end |=> state == ST_EMIT && ch_cnt == '0, "good frame did not start channel run")
  `SFR_ASSERT(a_run_ends, state == ST_EMIT && cmd.load && cmd.last |=> state == ST_IDLE, "channel run did not end after last channel")
  `SFR_ASSERT_NEVER(a_load_when_full, cmd.load && !status.out_free, "result loaded into full output register")

endmodule

/* rtl/sfr_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  // input word
  input  logic [sfr_pkg::BYTE_W-1:0]          s_tdata,
  input  logic                                s_tuser,
  // output word
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sfr_pkg::OUT_W-1:0]           m_tdata,
  output logic [sfr_pkg::KIND_W-1:0]          m_tuser,
  output logic                                m_tlast,
  // register writes
  input  logic                                cfg_valid,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  // control
  input  sfr_pkg::ctl_cmd_t                   cmd,
  output sfr_pkg::ctl_status_t                status
);
  import sfr_pkg::*;

  localparam int FRAME_W = STORE_BYTES * BYTE_W;

  // configuration
  logic [TICK_W-1:0] gap_timeout;
  logic [TICK_W-1:0] rate_window;

  // parser and counters
  logic              in_frame;
  logic [POS_W-1:0]  byte_pos;
  logic [FRAME_W-1:0] frame_reg;
  logic [TICK_W-1:0] idle_ticks;
  logic [TICK_W-1:0] window_ticks;
  logic [TICK_W-1:0] frames_in_window;
  logic [TICK_W-1:0] rate_latched;
  logic [CNT_W-1:0]  good_count;
  logic [CNT_W-1:0]  error_count;
  logic              lost_flag;
  logic              failsafe_flag;

  // output register
  kind_t               out_kind;
  logic [CH_IDX_W-1:0] out_idx;
  logic [CH_W-1:0]     out_val;
  logic                out_lost;
  logic                out_fs;
  logic [CNT_W-1:0]    out_ok;
  logic [CNT_W-1:0]    out_errs;
  logic [TICK_W-1:0]   out_rate;
  logic                out_last;

  logic              is_tick;
  logic [TICK_W-1:0] idle_inc;
  logic [TICK_W-1:0] win_inc;
  logic [POS_W-1:0]  pos_inc;
  logic [BYTE_W-1:0] flag_byte;

  // saturating tick increments, byte position increment, decode of the incoming word and output register status
  always_comb begin
    is_tick   = (s_tuser == REQ_TICK);
    idle_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
    win_inc   = (window_ticks == '1) ? window_ticks : window_ticks + 1'b1;
    pos_inc   = byte_pos + 1'b1;
    flag_byte = frame_reg[FRAME_W-1 -: BYTE_W];
    status.window_end = is_tick && (win_inc >= rate_window);
    status.frame_done = !is_tick && in_frame && (pos_inc == POS_W'(FRAME_LEN));
    status.end_ok     = (s_tdata == END_BYTE);
    status.out_free   = !m_tvalid || m_tready;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout <= GAP_RESET;
      rate_window <= WINDOW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_GAP) begin
        gap_timeout <= cfg_data;
      end else if (cfg_index == REG_WINDOW) begin
        rate_window <= cfg_data;
      end
    end
  end

  // parser, timeout and rate window
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      byte_pos         <= '0;
      idle_ticks       <= '0;
      window_ticks     <= '0;
      frames_in_window <= '0;
      rate_latched     <= '0;
      good_count       <= '0;
      error_count      <= '0;
      lost_flag        <= 1'b0;
      failsafe_flag    <= 1'b0;
    end else if (cmd.take) begin
      if (is_tick) begin
        idle_ticks <= idle_inc;
        if (idle_inc > gap_timeout) begin
          in_frame <= 1'b0;
          byte_pos <= '0;
        end
        if (status.window_end) begin
          rate_latched     <= frames_in_window;
          frames_in_window <= '0;
          window_ticks     <= '0;
        end else begin
          window_ticks <= win_inc;
        end
      end else begin
        idle_ticks <= '0;
        if (!in_frame) begin
          if (s_tdata == HDR_BYTE) begin
            in_frame <= 1'b1;
            byte_pos <= POS_W'(1);
          end
        end else if (status.frame_done) begin
          in_frame <= 1'b0;
          byte_pos <= '0;
          if (status.end_ok) begin
            lost_flag     <= flag_byte[LOST_BIT];
            failsafe_flag <= flag_byte[FS_BIT];
            good_count    <= good_count + 1'b1;
            if (frames_in_window != '1) begin
              frames_in_window <= frames_in_window + 1'b1;
            end
          end else begin
            error_count <= error_count + 1'b1;
          end
        end else begin
          byte_pos <= pos_inc;
        end
      end
    end
  end

  // frame bytes shift in at the top; channels shift out at the bottom
  always_ff @(posedge clk) begin
    if (cmd.take && !is_tick && in_frame) begin
      frame_reg <= {s_tdata, frame_reg[FRAME_W-1:BYTE_W]};
    end else if (cmd.shift_ch) begin
      frame_reg <= frame_reg >> CH_W;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload, counters and flags captured with the word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind <= cmd.kind;
      out_idx  <= cmd.ch_idx;
      out_val  <= (cmd.kind == KIND_CHANNEL) ? frame_reg[CH_W-1:0] : '0;
      out_lost <= lost_flag;
      out_fs   <= failsafe_flag;
      out_ok   <= good_count;
      out_errs <= error_count;
      out_rate <= rate_latched;
      out_last <= cmd.last;
    end
  end

  assign m_tuser = out_kind;
  assign m_tlast = out_last;
  assign m_tdata = {7'b0, out_rate, out_errs, out_ok,
                    out_fs, out_lost, out_val, out_idx};

  `SFR_ASSERT(a_hunt_pos, !in_frame |-> byte_pos == '0, "byte position set while hunting")
  `SFR_ASSERT(a_frame_pos, in_frame |-> (byte_pos != '0) && (byte_pos < POS_W'(FRAME_LEN)), "byte position out of frame")
  `SFR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "pending result changed")

endmodule

/* tb/sv/tb_sbus_frame_receiver_top.sv */
`timescale 1ns / 1ps

module tb_sbus_frame_receiver_top;
  import sfr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  // an index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;

  // one decoded result word
  typedef struct {
    kind_t               kind;
    logic [CH_IDX_W-1:0] ch;
    logic [CH_W-1:0]     value;
    logic                lost;
    logic                fs;
    logic [CNT_W-1:0]    ok;
    logic [CNT_W-1:0]    errs;
    logic [TICK_W-1:0]   rate;
    logic                last;
  } sbus_word_t;

  // frame decoder mirror and queue of decoded words still to arrive
  class sbus_scoreboard;
    logic [TICK_W-1:0] gap_limit;
    logic [TICK_W-1:0] window_len;
    bit                in_frame;
    int                pos;
    logic [7:0]        store [STORE_BYTES];
    logic [TICK_W-1:0] idle;
    logic [TICK_W-1:0] wticks;
    logic [TICK_W-1:0] win_frames;
    logic [TICK_W-1:0] rate;
    logic [CNT_W-1:0]  ok_cnt;
    logic [CNT_W-1:0]  err_cnt;
    logic              lost;
    logic              fs;
    sbus_word_t        decoded_q [$];
    int                errors;

    function new();
      gap_limit = GAP_RESET;
      window_len = WINDOW_RESET;
      in_frame = 0;
      pos = 0;
      foreach (store[i]) store[i] = '0;
      idle = '0;
      wticks = '0;
      win_frames = '0;
      rate = '0;
      ok_cnt = '0;
      err_cnt = '0;
      lost = 1'b0;
      fs = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_GAP) gap_limit = val;
      else if (idx == REG_WINDOW) window_len = val;
    endfunction

    function void push_word(kind_t kind, logic [CH_IDX_W-1:0] ch, logic [CH_W-1:0] value,
                            logic last);
      sbus_word_t w;
      w.kind = kind;
      w.ch = ch;
      w.value = value;
      w.lost = lost;
      w.fs = fs;
      w.ok = ok_cnt;
      w.errs = err_cnt;
      w.rate = rate;
      w.last = last;
      decoded_q.push_back(w);
    endfunction

    // advance the decoder by one accepted input word
    function void decode_word(logic req, logic [BYTE_W-1:0] b);
      logic [NUM_CH*CH_W-1:0] bits;
      if (req == REQ_TICK) begin
        if (idle != '1) idle++;
        if (idle > gap_limit) begin
          in_frame = 0;
          pos = 0;
        end
        if (wticks != '1) wticks++;
        if (wticks >= window_len) begin
          rate = win_frames;
          win_frames = '0;
          wticks = '0;
          push_word(KIND_RATE, '0, '0, 1'b1);
        end
        return;
      end
      idle = '0;
      if (!in_frame) begin
        if (b == HDR_BYTE) begin
          in_frame = 1;
          pos = 1;
        end
        return;
      end
      store[pos-1] = b;
      pos++;
      if (pos < FRAME_LEN) return;
      in_frame = 0;
      pos = 0;
      if (store[STORE_BYTES-1] != END_BYTE) begin
        err_cnt++;
        push_word(KIND_ERROR, '0, '0, 1'b1);
        return;
      end
      lost = store[STORE_BYTES-2][LOST_BIT];
      fs = store[STORE_BYTES-2][FS_BIT];
      ok_cnt++;
      if (win_frames != '1) win_frames++;
      // channels are packed little-endian over the first 22 stored bytes
      for (int i = 0; i < NUM_CH * CH_W / 8; i++) bits[8*i +: 8] = store[i];
      for (int k = 0; k < NUM_CH; k++)
        push_word(KIND_CHANNEL, k[CH_IDX_W-1:0], bits[CH_W*k +: CH_W], k == NUM_CH - 1);
    endfunction

    function void cmp_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [OUT_W-1:0] data, logic [KIND_W-1:0] kind, logic last);
      sbus_word_t want;
      if (decoded_q.size() == 0) begin
        $error("result word with nothing expected: kind %0d data %h", kind, data);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      cmp_field("result_kind", want.kind, kind);
      cmp_field("channel_index", want.ch, data[3:0]);
      cmp_field("channel_value", want.value, data[14:4]);
      cmp_field("frame_lost", want.lost, data[15]);
      cmp_field("failsafe", want.fs, data[16]);
      cmp_field("frames_ok", want.ok, data[48:17]);
      cmp_field("frame_errors", want.errs, data[80:49]);
      cmp_field("packet_rate", want.rate, data[96:81]);
      cmp_field("zero pad", '0, data[OUT_W-1:97]);
      cmp_field("last_of_run", want.last, last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;   // rx_byte
  logic                  s_tuser = 1'b0; // req_type
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // channel_index, channel_value, frame_lost, failsafe, frames_ok,
  // frame_errors, packet_rate, zero pad
  logic [OUT_W-1:0]      m_tdata;
  logic [KIND_W-1:0]     m_tuser;        // result_kind
  logic                  m_tlast;        // last_of_run
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sbus_scoreboard sb = new();
  bit no_idle = 0;
  int stall_cycles = 0;
  int sent_items = 0;
  logic [TICK_W-1:0] cur_gap = GAP_RESET;
  logic [7:0] frame_body [STORE_BYTES];

  sbus_frame_receiver_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);
    m_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one input word; valid stays high afterwards until the next idle or drain
  task automatic send_word(input logic req, input logic [BYTE_W-1:0] b);
    while (!no_idle && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.decode_word(req, b);
    sent_items++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_word(REQ_TICK, BYTE_W'($urandom));
  endtask

  // header plus the 24 bytes in frame_body, optionally with single ticks between
  task automatic send_frame(input bit tick_gaps);
    send_word(REQ_BYTE, HDR_BYTE);
    for (int i = 0; i < STORE_BYTES; i++) begin
      if (tick_gaps && $urandom_range(3) == 0) send_word(REQ_TICK, BYTE_W'($urandom));
      send_word(REQ_BYTE, frame_body[i]);
    end
  endtask

  // stop sending and wait for every decoded word to come out
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [TICK_W-1:0] gap, input logic [TICK_W-1:0] win,
                              input bit with_spare);
    wait_results_done();
    write_reg(REG_GAP, gap);
    if (with_spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_WINDOW, win);
    cfg_valid <= 1'b0;
    cur_gap = gap;
  endtask

  // mostly well-formed frames, some cut short by a silence, some line noise
  task automatic random_traffic(input int n_items);
    int start;
    int roll;
    int n;
    start = sent_items;
    while (sent_items - start < n_items) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        foreach (frame_body[i]) frame_body[i] = 8'($urandom);
        frame_body[STORE_BYTES-1] = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255))
                                                             : END_BYTE;
        send_frame($urandom_range(3) == 0);
      end else if (roll < 84 && cur_gap < 16) begin
        n = $urandom_range(1, STORE_BYTES - 1);
        send_word(REQ_BYTE, HDR_BYTE);
        for (int i = 0; i < n; i++) send_word(REQ_BYTE, BYTE_W'($urandom));
        send_ticks(cur_gap + 1);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_word(REQ_BYTE, BYTE_W'($urandom));
        roll = $urandom_range(0, 6);
        send_ticks(roll);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: noise while hunting, then a frame of all-ones channels with both flags
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'hFF);
    foreach (frame_body[i]) frame_body[i] = 8'hFF;
    frame_body[STORE_BYTES-2] = 8'h0C;
    frame_body[STORE_BYTES-1] = END_BYTE;
    send_frame(1'b0);

    // gap and window of one tick: a rate word per tick, timeout cuts a frame short
    program_regs(16'd1, 16'd1, 1'b1);
    send_ticks(2);
    send_word(REQ_BYTE, HDR_BYTE);
    send_word(REQ_BYTE, 8'h12);
    send_word(REQ_BYTE, 8'h34);
    send_ticks(2);
    send_word(REQ_BYTE, 8'h42);
    // all-zero frame with a bad end byte
    foreach (frame_body[i]) frame_body[i] = 8'h00;
    frame_body[STORE_BYTES-1] = 8'h80;
    send_frame(1'b0);

    // gap of 65534 ticks and longest window
    program_regs(16'd65534, 16'd65535, 1'b0);
    random_traffic(12);
    wait_results_done();
    random_traffic(12);

    // short window and gap, no idling on either side
    program_regs(16'd3, 16'd5, 1'b0);
    no_idle = 1;
    random_traffic(28);
    wait_results_done();
    no_idle = 0;

    program_regs(TICK_W'($urandom_range(2, 8)), TICK_W'($urandom_range(2, 12)), 1'b1);
    random_traffic(28);

    wait_results_done();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_ctrl.sv
rtl/sfr_datapath.sv
rtl/sbus_frame_receiver_top.sv
tb/sv/tb_sbus_frame_receiver_top.sv
